// ----- hdl/srfd_pkg.sv -----
package srfd_pkg;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CODE_W    = 8;
  localparam int RUN_W     = 7;
  localparam int COL_W     = 10;
  localparam int ADDR_W    = 18;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CODE_W-1:0] EOL_CODE   = 8'h80;
  localparam logic [RUN_W-1:0]  RUN_MASK   = 7'h7F;
  localparam logic [COL_W-1:0]  COLUMN_MAX = '1;

  localparam logic [1:0] OP_LIT  = 2'd0;
  localparam logic [1:0] OP_EOL  = 2'd1;
  localparam logic [1:0] OP_SKIP = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CODE_W-1:0] data;
  } srfd_op_t;

endpackage

// ----- hdl/srfd_front.sv -----
module srfd_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     restart,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [srfd_pkg::CODE_W-1:0] code_byte,
  input  logic                     q_full,
  output logic                     push,
  output srfd_pkg::srfd_op_t       push_op
);
  import srfd_pkg::*;

  logic [RUN_W-1:0] literals_left;
  logic [RUN_W-1:0] literals_left_next;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // classify the beat: literal while a run is open, else a control byte
  always_comb begin
    literals_left_next = literals_left;
    push               = 1'b0;
    push_op.kind       = OP_LIT;
    push_op.data       = code_byte;
    if (accept) begin
      if (literals_left != '0) begin
        literals_left_next = literals_left - 1'b1;
        push               = 1'b1;
      end else if (code_byte == EOL_CODE) begin
        push         = 1'b1;
        push_op.kind = OP_EOL;
      end else if (code_byte[CODE_W-1]) begin
        push         = 1'b1;
        push_op.kind = OP_SKIP;
      end else begin
        // open a literal run; nothing for the back end yet
        literals_left_next = code_byte[RUN_W-1:0] & RUN_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      literals_left <= '0;
    end else begin
      literals_left <= literals_left_next;
    end
  end

endmodule

// ----- hdl/srfd_queue.sv -----
module srfd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  srfd_pkg::srfd_op_t push_op,
  input  logic               pop,
  output logic               q_valid,
  output logic               q_full,
  output srfd_pkg::srfd_op_t q_op
);
  import srfd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  srfd_op_t           mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign q_valid = count != '0;
  assign q_full  = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign q_op    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/srfd_back.sv -----
module srfd_back #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]         eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]        eff_h,
  input  logic                                   q_valid,
  input  srfd_pkg::srfd_op_t                     q_op,
  output logic                                   pop,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   write_valid,
  output logic [srfd_pkg::ADDR_W-1:0]            pixel_address,
  output logic [srfd_pkg::CODE_W-1:0]            pixel_value,
  output logic                                   frame_end,
  output logic                                   overrun
);
  import srfd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = RW + WW;
  localparam int DW = (WW > COL_W) ? WW : COL_W;

  logic [COL_W-1:0]  column;
  logic [COL_W-1:0]  column_next;
  logic [RW-1:0]     row;
  logic [RW-1:0]     row_next;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] row_base_next;
  logic              reload;

  logic [RW-1:0]     row_top;
  logic [PW-1:0]     start_prod;
  logic [ADDR_W-1:0] start_base;
  logic              in_frame;
  logic [COL_W:0]    skip_sum;
  logic [COL_W-1:0]  column_inc;
  logic              out_free;
  logic              has_result;
  logic              res_write;
  logic              res_end;
  logic              res_over;
  logic [ADDR_W-1:0] res_addr;
  logic [CODE_W-1:0] res_value;

  assign row_top    = RW'(eff_h - 1'b1);
  assign start_prod = PW'(row_top) * PW'(eff_w);
  assign start_base = ADDR_W'(start_prod);

  assign in_frame   = DW'(column) < DW'(eff_w);
  assign skip_sum   = {1'b0, column} + (COL_W+1)'(q_op.data[RUN_W-1:0] & RUN_MASK);
  assign column_inc = (column == COLUMN_MAX) ? column : column + 1'b1;

  assign out_free = !out_valid || !out_stall;
  assign pop      = q_valid && out_free && !reload;

  always_comb begin
    column_next   = column;
    row_next      = row;
    row_base_next = row_base;
    has_result    = 1'b0;
    res_write     = 1'b0;
    res_end       = 1'b0;
    res_over      = 1'b0;
    res_addr      = '0;
    res_value     = '0;
    if (reload) begin
      column_next   = '0;
      row_next      = row_top;
      row_base_next = start_base;
    end else if (pop) begin
      case (q_op.kind)
        OP_LIT: begin
          has_result = 1'b1;
          if (in_frame) begin
            res_write = 1'b1;
            res_addr  = row_base + ADDR_W'(column);
            res_value = q_op.data;
          end else begin
            res_over = 1'b1;
          end
          column_next = column_inc;
        end
        OP_EOL: begin
          if (row == '0) begin
            has_result    = 1'b1;
            res_end       = 1'b1;
            column_next   = '0;
            row_next      = row_top;
            row_base_next = start_base;
          end else begin
            column_next   = '0;
            row_next      = row - 1'b1;
            row_base_next = row_base - ADDR_W'(eff_w);
          end
        end
        OP_SKIP: begin
          column_next = skip_sum[COL_W] ? COLUMN_MAX : skip_sum[COL_W-1:0];
        end
        default: begin
          column_next = column;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      row      <= '0;
      row_base <= '0;
      reload   <= 1'b0;
    end else if (restart) begin
      // new geometry: load row base once the registers have settled
      column   <= '0;
      reload   <= 1'b1;
    end else begin
      column   <= column_next;
      row      <= row_next;
      row_base <= row_base_next;
      reload   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pop && has_result) begin
      write_valid   <= res_write;
      pixel_address <= res_addr;
      pixel_value   <= res_value;
      frame_end     <= res_end;
      overrun       <= res_over;
    end
  end

endmodule

// ----- hdl/sprite_rle_frame_decoder_top.sv -----
// Run-length sprite frame decoder: takes one compressed byte per beat and
// emits pixel writes (row*width+column), overrun reports for literals past
// the frame width, and a frame_end beat on end-of-line at row zero. It
// sustains one byte per cycle while the output is not stalled; an accepted
// byte passes a two-entry queue between the byte classifier and the pixel
// unit, then the output register. Run headers, skips and inner
// end-of-line bytes give no output beat. Transparent pixels are not written,
// so clear the destination first. Write frame_width or frame_height only
// while idle; each write restarts the frame at the bottom row, and the
// pixel unit spends the cycle after the write loading the new row base.
module sprite_rle_frame_decoder_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [srfd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srfd_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [srfd_pkg::CODE_W-1:0]          code_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 write_valid,
  output logic [srfd_pkg::ADDR_W-1:0]          pixel_address,
  output logic [srfd_pkg::CODE_W-1:0]          pixel_value,
  output logic                                 frame_end,
  output logic                                 overrun
);
  import srfd_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH+1);
  localparam int HW  = $clog2(MAX_HEIGHT+1);
  localparam int DWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int DHW = (HW > CFG_W) ? HW : CFG_W;

  logic [WW-1:0]  eff_w;
  logic [HW-1:0]  eff_h;
  logic [DWW-1:0] w_ext;
  logic [DHW-1:0] h_ext;
  logic [DWW-1:0] w_clamp;
  logic [DHW-1:0] h_clamp;

  logic     push;
  srfd_op_t push_op;
  logic     pop;
  logic     q_valid;
  logic     q_full;
  srfd_op_t q_op;

  // clamp at write time: zero acts as one, oversize acts as the maximum
  assign w_ext = DWW'(cfg_data);
  assign h_ext = DHW'(cfg_data);

  always_comb begin
    if (w_ext == '0) begin
      w_clamp = DWW'(1);
    end else if (w_ext > DWW'(MAX_WIDTH)) begin
      w_clamp = DWW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    if (h_ext == '0) begin
      h_clamp = DHW'(1);
    end else if (h_ext > DHW'(MAX_HEIGHT)) begin
      h_clamp = DHW'(MAX_HEIGHT);
    end else begin
      h_clamp = h_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= WW'(1);
      eff_h <= HW'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  eff_w <= WW'(w_clamp);
        REG_FRAME_HEIGHT: eff_h <= HW'(h_clamp);
        default: begin
          eff_w <= eff_w;
        end
      endcase
    end
  end

  srfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (cfg_write),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .code_byte (code_byte),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  srfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .q_op    (q_op)
  );

  srfd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .restart       (cfg_write),
    .eff_w         (eff_w),
    .eff_h         (eff_h),
    .q_valid       (q_valid),
    .q_op          (q_op),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .write_valid   (write_valid),
    .pixel_address (pixel_address),
    .pixel_value   (pixel_value),
    .frame_end     (frame_end),
    .overrun       (overrun)
  );

  a_write_xor_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(write_valid && overrun))
    else $error("pixel write and overrun in one beat");

  a_frame_end_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (!write_valid && !overrun))
    else $error("frame_end beat carries a pixel result");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_valid) |-> (pixel_address == '0 && pixel_value == '0))
    else $error("non-write beat has nonzero address or value");

  a_queue_stall: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> !q_full)
    else $error("queue full after a pop with no push");

endmodule
